// ===== hdl/assert_macros.svh =====
// assertion macros shared by the solver rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/c3s_pkg.sv =====
// shared constants for the 3x3 cramer solver
// no dependencies; used by c3s_det3 and the top level
`timescale 1ns / 1ps
package c3s_pkg;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  // determinant pipeline: a*b, split partial products, recombine, pair sums, total
  localparam int DET_STAGES = 5;
  // element indexes of the six triple products of a row-major 3x3 determinant
  localparam int TERM_IDX [6][3] = '{
    '{0, 4, 8}, '{0, 5, 7}, '{1, 3, 8}, '{1, 5, 6}, '{2, 3, 7}, '{2, 4, 6}
  };
endpackage

// ===== hdl/c3s_det3.sv =====
// pipelined exact 3x3 determinant, five register stages
// depends on c3s_pkg; stage enables come from the top level valid chain
`timescale 1ns / 1ps
module c3s_det3 #(
  parameter int W = c3s_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic [c3s_pkg::DET_STAGES-1:0] adv,
  input  logic signed [W-1:0]   m [9],
  output logic signed [3*W+2:0] det
);
  localparam int DW = 3 * W + 3;

  logic signed [2*W-1:0] ab [6];
  logic signed [W-1:0]   cc [6];
  logic signed [2*W:0]   pl [6];
  logic signed [2*W-1:0] ph [6];
  logic signed [DW-1:0]  prod [6];
  logic signed [DW-1:0]  psum [3];

  for (genvar t = 0; t < 6; t++) begin : g_term
    always_ff @(posedge clk) begin
      if (adv[0]) begin
        ab[t] <= m[c3s_pkg::TERM_IDX[t][0]] * m[c3s_pkg::TERM_IDX[t][1]];
        cc[t] <= m[c3s_pkg::TERM_IDX[t][2]];
      end
      // split the 2w product so each multiply stays about w by w
      if (adv[1]) begin
        pl[t] <= $signed({1'b0, ab[t][W-1:0]}) * cc[t];
        ph[t] <= $signed(ab[t][2*W-1:W]) * cc[t];
      end
      if (adv[2]) begin
        prod[t] <= $signed({{(DW-3*W){ph[t][2*W-1]}}, ph[t], {W{1'b0}}})
                 + $signed({{(DW-2*W-1){pl[t][2*W]}}, pl[t]});
      end
    end
  end

  // term signs: + - - + + -
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      psum[0] <= prod[0] - prod[1];
      psum[1] <= prod[3] - prod[2];
      psum[2] <= prod[4] - prod[5];
    end
    if (adv[4]) begin
      det <= psum[0] + psum[1] + psum[2];
    end
  end
endmodule

// ===== hdl/c3s_div.sv =====
// pipelined restoring divider: one quotient bit per stage, saturation detect up front
// no package dependency; stage enables come from the top level valid chain
`timescale 1ns / 1ps
module c3s_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic             clk,
  input  logic [W:0]       adv,
  input  logic [3*W+2:0]   num,
  input  logic [3*W+2:0]   den,
  input  logic             neg_in,
  output logic [W-1:0]     quo,
  output logic             ovf,
  output logic             neg
);
  localparam int DW = 3 * W + 3;
  localparam int RW = DW + W;
  localparam int CW = (DW + F > RW) ? DW + F : RW;

  logic [RW-1:0] rem  [W+1];
  logic [DW-1:0] dv   [W+1];
  logic [W-1:0]  q    [W+1];
  logic          ovfp [W+1];
  logic          negp [W+1];
  logic [CW-1:0] num_sh;
  logic [CW-1:0] den_sh;

  assign num_sh = CW'(num) << F;
  assign den_sh = CW'(den) << W;

  // quotient of 2^w or more saturates; otherwise the remainder fits rw bits
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem[0]  <= num_sh[RW-1:0];
      dv[0]   <= den;
      q[0]    <= '0;
      ovfp[0] <= (num_sh >= den_sh);
      negp[0] <= neg_in;
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_bit
    logic [RW:0] diff;
    assign diff = {1'b0, rem[s-1]} - {1'b0, RW'(dv[s-1]) << (W - s)};
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        rem[s]  <= diff[RW] ? rem[s-1] : diff[RW-1:0];
        q[s]    <= {q[s-1][W-2:0], ~diff[RW]};
        dv[s]   <= dv[s-1];
        ovfp[s] <= ovfp[s-1];
        negp[s] <= negp[s-1];
      end
    end
  end

  assign quo = q[W];
  assign ovf = ovfp[W];
  assign neg = negp[W];
endmodule

// ===== hdl/cramer_3x3_linear_solver.sv =====
// 3x3 linear system solver by cramer's rule, signed fixed point
// depends on c3s_pkg, c3s_det3, c3s_div and assert_macros.svh
//
// usage: one system enters per s_tvalid/s_tready transaction on s_tdata
// (nine coefficients row-major, then the three right-hand sides). one
// transaction on m_tdata/m_tuser returns x, y, z plus singular and saturated.
// stages in order: five determinant stages, one magnitude stage,
// one overflow-check stage, WORD_WIDTH quotient stages and the output
// register. throughput is one system per cycle while the receiver takes
// results; the restoring divider gives one quotient bit per stage.
// every stage has its own valid bit and advances when empty or when the
// stage ahead advances, so bubbles are squeezed out while the receiver
// stalls and s_tready drops only once every stage holds a system.
// reset clears all valid bits; data registers are not reset.
// a zero main determinant gives zero unknowns with singular set.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cramer_3x3_linear_solver #(
  parameter int WORD_WIDTH = c3s_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = c3s_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // coef_r0c0..coef_r2c2, rhs_0, rhs_1, rhs_2
  input  logic [((12*WORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // sol_x, sol_y, sol_z
  output logic [((3*WORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // singular, saturated
  output logic [1:0] m_tuser
);
  localparam int W   = WORD_WIDTH;
  localparam int DW  = 3 * W + 3;
  localparam int DS  = c3s_pkg::DET_STAGES;
  localparam int NS  = W + DS + 3;
  localparam int ODW = ((3*W+7)/8)*8;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic [NS-1:0] v;
  logic [NS-1:0] adv;
  logic signed [W-1:0] a [9];
  logic signed [W-1:0] b [3];
  logic signed [W-1:0] mc [4][9];
  logic signed [DW-1:0] det [4];
  logic [DW-1:0] dmag [4];
  logic [2:0] negc;
  logic sing5;
  logic sing_p [W+1];
  logic [W-1:0] quo [3];
  logic ovf [3];
  logic negq [3];
  logic [W-1:0] sol [3];
  logic sing_o;
  logic sat_o;
  logic [W-1:0] val [3];
  logic [2:0] satc;

  always_comb begin
    adv[NS-1] = !v[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end
  assign s_tready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= s_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // main matrix and the three column-replaced matrices
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      a[i] = $signed(s_tdata[W*i +: W]);
    end
    for (int i = 0; i < 3; i++) begin
      b[i] = $signed(s_tdata[W*(9+i) +: W]);
    end
    for (int d = 0; d < 4; d++) begin
      for (int i = 0; i < 9; i++) begin
        mc[d][i] = (d > 0 && (i % 3) == d - 1) ? b[i / 3] : a[i];
      end
    end
  end

  for (genvar d = 0; d < 4; d++) begin : g_det
    c3s_det3 #(.W(W)) u_det (
      .clk (clk),
      .adv (adv[DS-1:0]),
      .m   (mc[d]),
      .det (det[d])
    );
  end

  always_ff @(posedge clk) begin
    if (adv[DS]) begin
      for (int d = 0; d < 4; d++) begin
        dmag[d] <= det[d][DW-1] ? (~$unsigned(det[d]) + {{(DW-1){1'b0}}, 1'b1})
                                : $unsigned(det[d]);
      end
      for (int c = 0; c < 3; c++) begin
        negc[c] <= det[c+1][DW-1] ^ det[0][DW-1];
      end
      sing5 <= (det[0] == '0);
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    c3s_div #(.W(W), .F(FRAC_BITS)) u_div (
      .clk    (clk),
      .adv    (adv[DS+W+1:DS+1]),
      .num    (dmag[c+1]),
      .den    (dmag[0]),
      .neg_in (negc[c]),
      .quo    (quo[c]),
      .ovf    (ovf[c]),
      .neg    (negq[c])
    );
  end

  // singular flag rides alongside the divider stages
  always_ff @(posedge clk) begin
    if (adv[DS+1]) begin
      sing_p[0] <= sing5;
    end
    for (int s = 1; s <= W; s++) begin
      if (adv[DS+1+s]) begin
        sing_p[s] <= sing_p[s-1];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      satc[c] = ovf[c] || (quo[c] > (negq[c] ? SMIN : SMAX));
      if (sing_p[W]) begin
        val[c] = '0;
      end else if (satc[c]) begin
        val[c] = negq[c] ? SMIN : SMAX;
      end else begin
        val[c] = negq[c] ? (~quo[c] + {{(W-1){1'b0}}, 1'b1}) : quo[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      sol    <= val;
      sing_o <= sing_p[W];
      sat_o  <= !sing_p[W] && (satc != '0);
    end
  end

  assign m_tvalid = v[NS-1];
  assign m_tdata  = ODW'({sol[2], sol[1], sol[0]});
  assign m_tuser  = {sat_o, sing_o};

  `ASSERT_IMP(a_sing_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == '0 && !m_tuser[1], "singular result not zero")
  `ASSERT_IMP(a_full_stall, clk, rst, !s_tready, m_tvalid && !m_tready && v == '1, "input stalled with room in pipeline")
  `ASSERT_IMP(a_sat_extreme, clk, rst, m_tvalid && m_tuser[1], sol[0] == SMAX || sol[0] == SMIN || sol[1] == SMAX || sol[1] == SMIN || sol[2] == SMAX || sol[2] == SMIN, "saturated without clipped unknown")
  `ASSERT_NXT(a_drain, clk, rst, m_tvalid && m_tready && !v[NS-2], !m_tvalid, "result repeated after drain")
endmodule
